>>> rtl/smst_pkg.sv
// ----------------------------------------------------------------------------
// smst_pkg: shared types and constants for the sequenced mailbox slot table
// Holds command and status codes and the default table depth.
// ----------------------------------------------------------------------------
package smst_pkg;

	localparam int unsigned DefSlots = 16;

	typedef enum logic [2:0] {
		CMD_ACCEPT    = 3'd0,
		CMD_RECONCILE = 3'd1,
		CMD_POLL_INST = 3'd2,
		CMD_POLL_SCHD = 3'd3,
		CMD_CONFIRM   = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_ALREADY = 3'd1,
		ST_GAP     = 3'd2,
		ST_FULL    = 3'd3,
		ST_INVALID = 3'd4,
		ST_NOTDONE = 3'd5
	} status_t;

endpackage

>>> rtl/sequenced_mailbox_slot_table.sv
// ----------------------------------------------------------------------------
// sequenced_mailbox_slot_table: slot table of messages with an in-order cursor
// Stores messages in a synchronous memory and scans it once per request.
// ----------------------------------------------------------------------------
//  channel  | handshake            | fields
//  request  | start / busy         | command, sequence_number, message_type,
//           |                      | release_epoch, text_valid, msg_colour,
//           |                      | now_epoch, sink_accepts
//  result   | done (one cycle)     | status, issued, issued_*, accepted_cursor,
//           |                      | num_instant, num_scheduled,
//           |                      | earliest_epoch, due_pending
//
// Every request runs through the scan (one read issued per slot, the read
// data registered on the port, a step to close the scan), a decide step
// with write-back and an output step that raises done. busy is already low
// while done is high, so the next request can be taken at the edge that ends
// done; a new request is not taken while the last one is still in flight.
// Reset clears the used bits, the cursor, the in-flight mark and the summary;
// the slot payload memory is not cleared. The receiver cannot stall: done is
// a one-cycle strobe, and busy stays high from acceptance until it.
// ----------------------------------------------------------------------------
module sequenced_mailbox_slot_table #(
	parameter int unsigned SLOTS = smst_pkg::DefSlots
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [2:0]  command,
	input  logic [63:0] sequence_number,
	input  logic [1:0]  message_type,
	input  logic signed [63:0] release_epoch,
	input  logic        text_valid,
	input  logic [15:0] msg_colour,
	input  logic signed [63:0] now_epoch,
	input  logic        sink_accepts,
	output logic [2:0]  status,
	output logic        issued,
	output logic [63:0] issued_sequence,
	output logic [7:0]  issued_slot,
	output logic [15:0] issued_color,
	output logic [63:0] accepted_cursor,
	output logic [7:0]  num_instant,
	output logic [7:0]  num_scheduled,
	output logic [62:0] earliest_epoch,
	output logic        due_pending
);

	localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_OUT} state_t;

	state_t state_q;
	logic [CW-1:0] idx_q;     // address being issued
	logic          rvld_s1;   // read data valid this cycle
	logic [IW-1:0] ridx_s1;   // address of the data on the read port

	// slot memory: sequence, kind, epoch, colour in one word
	logic [143:0] slot_mem [SLOTS];
	logic [143:0] rd_word_q;
	logic [63:0] rd_seq;
	logic        rd_kind;
	logic [62:0] rd_ep;
	logic [15:0] rd_col;
	logic        we;
	logic [IW-1:0] waddr;
	logic [SLOTS-1:0] used_q;

	// latched request
	logic [2:0]  cmd_q;
	logic [63:0] seq_q;
	logic [1:0]  type_q;
	logic [63:0] trig_q;
	logic        text_q;
	logic [15:0] col_q;
	logic signed [63:0] now_q;
	logic        sink_q;

	// architectural state
	logic [63:0] cursor_q, inflight_q;
	logic [7:0]  ni_q, ns_q;
	logic [62:0] min_q;

	// scan accumulators
	logic          free_f_q;  logic [IW-1:0] free_i_q;
	logic          blk_q;
	logic          hit_f_q;   logic [IW-1:0] hit_i_q;
	logic          ins_f_q;   logic [IW-1:0] ins_i_q; logic [63:0] ins_seq_q;
	logic [15:0]   ins_col_q;
	logic          due_f_q;   logic [IW-1:0] due_i_q; logic [63:0] due_seq_q;
	logic [62:0]   due_ep_q;  logic [15:0] due_col_q;
	// rebuild with the confirmed slot taken out
	logic [7:0]    rni_q, rns_q; logic [62:0] rmin_q;
	// due status against the state after the step (confirm removes one slot)
	logic          dall_q;    // any due among all used
	logic          dexc_q;    // any due excluding the confirm hit

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[waddr] <= {seq_q, type_q[0],
				(type_q[0] ? trig_q[62:0] : 63'd0), col_q};
		end
		rd_word_q <= slot_mem[idx_q[IW-1:0]];
	end

	assign {rd_seq, rd_kind, rd_ep, rd_col} = rd_word_q;

	// per-entry view of the read data
	logic e_used, e_inst, e_schd, e_due, e_hit;
	assign e_used = rvld_s1 && used_q[ridx_s1];
	assign e_inst = e_used && !rd_kind;
	assign e_schd = e_used && rd_kind;
	assign e_due  = e_schd && ($signed({1'b0, rd_ep}) <= now_q);
	assign e_hit  = e_used && (rd_seq == seq_q) && !hit_f_q;

	// decide
	logic acc_ok, valid_in;
	logic [63:0] cur_p1;
	assign cur_p1   = cursor_q + 64'd1;
	assign valid_in = (seq_q != 64'd0) && !type_q[1] && text_q &&
		!(type_q[0] && ($signed(trig_q) <= 64'sd0));
	assign acc_ok = (cmd_q == smst_pkg::CMD_ACCEPT) && valid_in &&
		(seq_q > cursor_q) && (seq_q == cur_p1) && free_f_q;

	always_comb begin
		we    = (state_q == S_DECIDE) && acc_ok;
		waddr = free_i_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			idx_q      <= '0;
			rvld_s1    <= 1'b0;
			ridx_s1    <= '0;
			used_q     <= '0;
			cursor_q   <= '0;
			inflight_q <= '0;
			ni_q       <= '0;
			ns_q       <= '0;
			min_q      <= '0;
			done       <= 1'b0;
		end else begin
			done    <= 1'b0;
			rvld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q  <= command;
						seq_q  <= sequence_number;
						type_q <= message_type;
						trig_q <= release_epoch;
						text_q <= text_valid;
						col_q  <= msg_colour;
						now_q  <= now_epoch;
						sink_q <= sink_accepts;
						idx_q  <= '0;
						free_f_q <= 1'b0; blk_q <= 1'b0; hit_f_q <= 1'b0;
						ins_f_q <= 1'b0; due_f_q <= 1'b0;
						rni_q <= '0; rns_q <= '0; rmin_q <= '0;
						dall_q <= 1'b0; dexc_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// issue reads; accumulate the one returning
					if (idx_q < CW'(SLOTS)) begin
						rvld_s1 <= 1'b1;
						ridx_s1 <= idx_q[IW-1:0];
						idx_q   <= idx_q + CW'(1);
					end
					if (rvld_s1) begin
						if (!used_q[ridx_s1] && !free_f_q) begin
							free_f_q <= 1'b1; free_i_q <= ridx_s1;
						end
						if (e_used && rd_seq > cursor_q) blk_q <= 1'b1;
						if (e_hit) begin
							hit_f_q <= 1'b1; hit_i_q <= ridx_s1;
						end
						if (e_inst && (!ins_f_q || rd_seq < ins_seq_q)) begin
							ins_f_q <= 1'b1; ins_i_q <= ridx_s1;
							ins_seq_q <= rd_seq; ins_col_q <= rd_col;
						end
						if (e_due && (!due_f_q || rd_ep < due_ep_q ||
								(rd_ep == due_ep_q && rd_seq < due_seq_q))) begin
							due_f_q <= 1'b1; due_i_q <= ridx_s1;
							due_seq_q <= rd_seq; due_ep_q <= rd_ep; due_col_q <= rd_col;
						end
						if (e_due) dall_q <= 1'b1;
						if (e_due && !e_hit) dexc_q <= 1'b1;
						// rebuild leaves out the first match of the confirm
						if (!e_hit) begin
							if (e_inst) rni_q <= rni_q + 8'd1;
							if (e_schd) begin
								rns_q <= rns_q + 8'd1;
								if (rmin_q == 63'd0 || rd_ep < rmin_q) rmin_q <= rd_ep;
							end
						end
					end
					if (idx_q == CW'(SLOTS) && !rvld_s1) state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					state_q <= S_OUT;
					issued <= 1'b0; issued_sequence <= '0; issued_slot <= '0;
					issued_color <= '0;
					status <= smst_pkg::ST_NOTDONE;
					due_pending <= (ns_q != 8'd0) && (min_q != 63'd0) &&
						($signed({1'b0, min_q}) <= now_q) && dall_q;
					case (cmd_q)
						smst_pkg::CMD_ACCEPT: begin
							if (!valid_in) status <= smst_pkg::ST_INVALID;
							else if (seq_q <= cursor_q) status <= smst_pkg::ST_ALREADY;
							else if (seq_q != cur_p1) status <= smst_pkg::ST_GAP;
							else if (!free_f_q) status <= smst_pkg::ST_FULL;
							else begin
								status <= smst_pkg::ST_DONE;
								used_q[free_i_q] <= 1'b1;
								cursor_q <= seq_q;
								if (type_q[0]) begin
									ns_q <= ns_q + 8'd1;
									if (min_q == 63'd0 || trig_q[62:0] < min_q)
										min_q <= trig_q[62:0];
									// new message is due if its epoch has passed
									if ($signed(trig_q) <= now_q) due_pending <= 1'b1;
								end else begin
									ni_q <= ni_q + 8'd1;
								end
							end
						end
						smst_pkg::CMD_RECONCILE: begin
							if (seq_q == 64'd0 || seq_q <= cursor_q) begin
								status <= smst_pkg::ST_DONE;
							end else if (!blk_q) begin
								status <= smst_pkg::ST_DONE;
								cursor_q <= seq_q;
							end
						end
						smst_pkg::CMD_POLL_INST: begin
							if (inflight_q == 64'd0 && ni_q != 8'd0 && ins_f_q && sink_q) begin
								status <= smst_pkg::ST_DONE;
								inflight_q <= ins_seq_q;
								issued <= 1'b1; issued_sequence <= ins_seq_q;
								issued_slot <= 8'(ins_i_q); issued_color <= ins_col_q;
							end
						end
						smst_pkg::CMD_POLL_SCHD: begin
							if (inflight_q == 64'd0 && ns_q != 8'd0 && min_q != 63'd0 &&
									$signed({1'b0, min_q}) <= now_q && due_f_q && sink_q) begin
								status <= smst_pkg::ST_DONE;
								inflight_q <= due_seq_q;
								issued <= 1'b1; issued_sequence <= due_seq_q;
								issued_slot <= 8'(due_i_q); issued_color <= due_col_q;
							end
						end
						smst_pkg::CMD_CONFIRM: begin
							if (seq_q != 64'd0 && seq_q == inflight_q) begin
								inflight_q <= '0;
								if (hit_f_q) begin
									status <= smst_pkg::ST_DONE;
									used_q[hit_i_q] <= 1'b0;
									ni_q <= rni_q; ns_q <= rns_q; min_q <= rmin_q;
									due_pending <= (rns_q != 8'd0) && (rmin_q != 63'd0) &&
										($signed({1'b0, rmin_q}) <= now_q) && dexc_q;
								end
							end
						end
						default: ;
					endcase
				end
				S_OUT: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign accepted_cursor = cursor_q;
	assign num_instant     = ni_q;
	assign num_scheduled   = ns_q;
	assign earliest_epoch  = min_q;

`ifndef ASSERT_OFF
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy while the result is presented");
	a_issue_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(done && issued) |-> inflight_q == issued_sequence)
		else $error("issued message not in flight");
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(ni_q) + 32'(ns_q)) <= 32'($countones(used_q)))
		else $error("counts exceed used slots");
	a_min_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(ns_q == 8'd0) |-> (min_q == 63'd0)) else $error("stale earliest epoch");
`endif

endmodule
